// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/swt_pkg.sv =====
package swt_pkg;

    localparam int MaxResults = 3;

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_WORD    = 3'd1,
        MODE_SQ      = 3'd2,
        MODE_DQ      = 3'd3,
        MODE_DOLQ    = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2,
        KIND_ERR  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_line;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } t_decode;

    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_V         = 8'h76;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // escape decode inside $'...'
    function automatic t_decode decode(input logic [7:0] c);
        t_decode d;
        d.hit   = 1'b1;
        d.value = c;
        case (c)
            CH_N:         d.value = 8'h0A;
            CH_R:         d.value = 8'h0D;
            CH_T:         d.value = 8'h09;
            CH_A:         d.value = 8'h07;
            CH_B:         d.value = 8'h08;
            CH_F:         d.value = 8'h0C;
            CH_V:         d.value = 8'h0B;
            CH_BACKSLASH: d.value = c;
            CH_SQUOTE:    d.value = c;
            CH_DQUOTE:    d.value = c;
            default:      d.hit = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/shell_word_tokenizer.sv =====
// Shell-style word splitter. Each input transfer carries one byte of a command line, or the
// end-of-line mark; it yields zero to three result transfers (word bytes, word ends, and on
// end of line either line done or an unterminated-quote error), the final one flagged by
// last. A byte is decoded combinationally against the lexer state and its results are
// loaded into a three-entry result buffer that drains one result per cycle unless the
// output stalls. A new byte is taken whenever the buffer holds at most one result that
// leaves in the same cycle, so bytes that cause zero or one result stream at one per cycle
// unless the output stalls; a byte with more results blocks input until its last leaves.
// Results of a line that ends in an error stand and are to be discarded by the consumer.
`include "assert_macros.svh"

module shell_word_tokenizer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  swt_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output swt_pkg::t_out_item  o_out_data
);

    swt_pkg::t_mode     r_mode;
    swt_pkg::t_mode     n_mode;
    logic               r_esc;
    logic               n_esc;
    logic               r_dol;
    logic               n_dol;
    logic [1:0]         r_cnt;
    swt_pkg::t_out_item r_res [swt_pkg::MaxResults];

    swt_pkg::t_out_item s_res [swt_pkg::MaxResults];
    logic [1:0]         s_cnt;
    logic               s_wb;
    logic [7:0]         c;
    swt_pkg::t_decode   dec;

    logic in_xfer;
    logic out_take;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_res[0];
    assign out_take    = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_cnt > 2'd1) || ((r_cnt == 2'd1) && i_out_stall);
    assign in_xfer     = i_in_valid && !o_in_stall;

    always_comb begin
        n_mode = r_mode;
        n_esc  = r_esc;
        n_dol  = r_dol;
        s_cnt  = 2'd0;
        s_wb   = 1'b0;
        c      = i_in_data.in_byte;
        dec    = swt_pkg::decode(c);
        for (int i = 0; i < swt_pkg::MaxResults; i++) begin
            s_res[i] = '{out_byte: 8'h00, kind: swt_pkg::KIND_BYTE, last: 1'b0};
        end

        if (i_in_data.end_of_line) begin
            n_mode = swt_pkg::MODE_BETWEEN;
            n_esc  = 1'b0;
            n_dol  = 1'b0;
            if (r_mode == swt_pkg::MODE_SQ || r_mode == swt_pkg::MODE_DQ ||
                r_mode == swt_pkg::MODE_DOLQ) begin
                s_res[s_cnt] = '{out_byte: 8'h00, kind: swt_pkg::KIND_ERR, last: 1'b0};
                s_cnt = s_cnt + 2'd1;
            end else begin
                if (r_esc) begin
                    s_res[s_cnt] = '{out_byte: swt_pkg::CH_BACKSLASH,
                                     kind: swt_pkg::KIND_BYTE, last: 1'b0};
                    s_cnt = s_cnt + 2'd1;
                end else if (r_dol) begin
                    s_res[s_cnt] = '{out_byte: swt_pkg::CH_DOLLAR,
                                     kind: swt_pkg::KIND_BYTE, last: 1'b0};
                    s_cnt = s_cnt + 2'd1;
                end
                if (r_mode == swt_pkg::MODE_WORD || r_esc) begin
                    s_res[s_cnt] = '{out_byte: 8'h00, kind: swt_pkg::KIND_END, last: 1'b0};
                    s_cnt = s_cnt + 2'd1;
                end
                s_res[s_cnt] = '{out_byte: 8'h00, kind: swt_pkg::KIND_DONE, last: 1'b0};
                s_cnt = s_cnt + 2'd1;
            end
        end else begin
            case (r_mode)
                swt_pkg::MODE_WORD: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        if (c != swt_pkg::CH_LF) begin
                            s_res[s_cnt] = '{out_byte: c, kind: swt_pkg::KIND_BYTE,
                                             last: 1'b0};
                            s_cnt = s_cnt + 2'd1;
                        end
                    end else if (r_dol) begin
                        n_dol = 1'b0;
                        if (c == swt_pkg::CH_SQUOTE) begin
                            n_mode = swt_pkg::MODE_DOLQ;
                        end else begin
                            s_res[s_cnt] = '{out_byte: swt_pkg::CH_DOLLAR,
                                             kind: swt_pkg::KIND_BYTE, last: 1'b0};
                            s_cnt = s_cnt + 2'd1;
                            s_wb = 1'b1;
                        end
                    end else begin
                        s_wb = 1'b1;
                    end
                end
                swt_pkg::MODE_SQ: begin
                    if (c == swt_pkg::CH_SQUOTE) begin
                        n_mode = swt_pkg::MODE_WORD;
                    end else begin
                        s_res[s_cnt] = '{out_byte: c, kind: swt_pkg::KIND_BYTE, last: 1'b0};
                        s_cnt = s_cnt + 2'd1;
                    end
                end
                swt_pkg::MODE_DQ: begin
                    if (c == swt_pkg::CH_DQUOTE) begin
                        n_mode = swt_pkg::MODE_WORD;
                    end else begin
                        s_res[s_cnt] = '{out_byte: c, kind: swt_pkg::KIND_BYTE, last: 1'b0};
                        s_cnt = s_cnt + 2'd1;
                    end
                end
                swt_pkg::MODE_DOLQ: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        if (dec.hit) begin
                            s_res[s_cnt] = '{out_byte: dec.value, kind: swt_pkg::KIND_BYTE,
                                             last: 1'b0};
                            s_cnt = s_cnt + 2'd1;
                        end else begin
                            s_res[s_cnt] = '{out_byte: swt_pkg::CH_BACKSLASH,
                                             kind: swt_pkg::KIND_BYTE, last: 1'b0};
                            s_cnt = s_cnt + 2'd1;
                            s_res[s_cnt] = '{out_byte: c, kind: swt_pkg::KIND_BYTE,
                                             last: 1'b0};
                            s_cnt = s_cnt + 2'd1;
                        end
                    end else if (c == swt_pkg::CH_SQUOTE) begin
                        n_mode = swt_pkg::MODE_WORD;
                    end else if (c == swt_pkg::CH_BACKSLASH) begin
                        n_esc = 1'b1;
                    end else begin
                        s_res[s_cnt] = '{out_byte: c, kind: swt_pkg::KIND_BYTE, last: 1'b0};
                        s_cnt = s_cnt + 2'd1;
                    end
                end
                default: begin
                    // between words
                    n_mode = swt_pkg::MODE_BETWEEN;
                    if (r_esc) begin
                        n_esc = 1'b0;
                        if (c != swt_pkg::CH_LF) begin
                            n_mode = swt_pkg::MODE_WORD;
                            s_res[s_cnt] = '{out_byte: c, kind: swt_pkg::KIND_BYTE,
                                             last: 1'b0};
                            s_cnt = s_cnt + 2'd1;
                        end
                    end else if (c == swt_pkg::CH_BACKSLASH) begin
                        n_esc = 1'b1;
                    end else if (!swt_pkg::is_space(c)) begin
                        n_mode = swt_pkg::MODE_WORD;
                        s_wb = 1'b1;
                    end
                end
            endcase

            // unescaped byte inside a word
            if (s_wb) begin
                if (swt_pkg::is_space(c)) begin
                    n_mode = swt_pkg::MODE_BETWEEN;
                    s_res[s_cnt] = '{out_byte: 8'h00, kind: swt_pkg::KIND_END, last: 1'b0};
                    s_cnt = s_cnt + 2'd1;
                end else if (c == swt_pkg::CH_SQUOTE) begin
                    n_mode = swt_pkg::MODE_SQ;
                end else if (c == swt_pkg::CH_DQUOTE) begin
                    n_mode = swt_pkg::MODE_DQ;
                end else if (c == swt_pkg::CH_DOLLAR) begin
                    n_dol = 1'b1;
                end else if (c == swt_pkg::CH_BACKSLASH) begin
                    n_esc = 1'b1;
                end else begin
                    s_res[s_cnt] = '{out_byte: c, kind: swt_pkg::KIND_BYTE, last: 1'b0};
                    s_cnt = s_cnt + 2'd1;
                end
            end
        end

        if (s_cnt != 2'd0) begin
            s_res[s_cnt - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= swt_pkg::MODE_BETWEEN;
        end else if (in_xfer) begin
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
            r_dol <= 1'b0;
            r_cnt <= 2'd0;
        end else if (in_xfer) begin
            r_esc <= n_esc;
            r_dol <= n_dol;
            r_cnt <= s_cnt;
        end else if (out_take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // result buffer, head in entry zero
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int i = 0; i < swt_pkg::MaxResults; i++) begin
                r_res[i] <= s_res[i];
            end
        end else if (out_take) begin
            for (int i = 0; i < swt_pkg::MaxResults - 1; i++) begin
                r_res[i] <= r_res[i + 1];
            end
        end
    end

    `ASSERT_CLK(a_accept_drained, in_xfer |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && out_take)), "item accepted while results still queued")
    `ASSERT_CLK(a_last_on_tail, (o_out_valid && r_cnt == 2'd1) |-> o_out_data.last, "final queued result lacks last")
    `ASSERT_CLK(a_eol_resets, (in_xfer && i_in_data.end_of_line) |=> (r_mode == swt_pkg::MODE_BETWEEN && !r_esc && !r_dol), "lexer state not cleared after end of line")
    `ASSERT_CLK(a_dollar_in_word, r_dol |-> (r_mode == swt_pkg::MODE_WORD && !r_esc), "dollar pending outside a word")
    `ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (r_cnt == 2'd0), "result buffer not empty after reset")

endmodule
